FILE: rtl/core/spqc_pkg.sv
// ============================================================================
// spqc_pkg: shared definitions for the stable priority queue with cancel
// Sizes, request and status codes, controller states and the command bundle
// that the controller hands to the datapath.
// ============================================================================
`default_nettype none

package spqc_pkg;

   // Storage sizing.
   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 16;
   localparam int FILL_W   = $clog2(CAPACITY + 1);

   // Fixed port field widths.
   localparam int TYPE_W = 2;
   localparam int KEY_W  = 16;
   localparam int URG_W  = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 7;

   // Request codes. The fourth code is unused and answers as a no-op.
   typedef enum logic [TYPE_W-1:0] {
      REQ_ENQ    = 2'd0,
      REQ_DEQ    = 2'd1,
      REQ_CANCEL = 2'd2
   } req_op_type;

   // Response status codes.
   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } rsp_status_type;

   // Controller states.
   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_LOOKUP = 2'd1,
      FSM_EXEC   = 2'd2
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;  // capture the request fields
      logic lookup;    // register the per-slot compare results
      logic commit;    // update the slots and load the response register
   } dp_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/core/stable_priority_queue_cancel.sv
// ============================================================================
// stable_priority_queue_cancel: ordered queue with three urgency levels
// Top level joining the request sequencer and the slot chain datapath.
// ============================================================================
// The block keeps up to 64 keyed entries in service order, most urgent first
// and first-in first-out within one urgency level. Each request beat gives
// exactly one response beat. An enqueue places the entry behind all entries
// of equal or better urgency, or answers full; a dequeue returns the head, or
// answers empty; a cancel removes the first entry whose key matches, or
// answers not found. Each request passes through two steps: a lookup
// comparing all slots against the request in parallel and registering
// the results, and an execute step shifting the slot chain and loading
// the response register. A new request is accepted in the same cycle
// that the previous one completes, so requests follow directly as long as
// the response side keeps taking beats; while a response waits, the
// current request stays in execute and the request side is not ready.
// An urgency of zero in an enqueue counts as urgency one, and the unused
// request code changes nothing and answers ok with the current occupancy.
`default_nettype none

module stable_priority_queue_cancel (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [spqc_pkg::TYPE_W-1:0] req_type,
   input  wire logic [spqc_pkg::KEY_W-1:0]  req_entry_key,
   input  wire logic [spqc_pkg::URG_W-1:0]  req_urgency,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [spqc_pkg::STAT_W-1:0] rsp_status,
   output logic      [spqc_pkg::KEY_W-1:0]  rsp_served_key,
   output logic      [spqc_pkg::URG_W-1:0]  rsp_served_urgency,
   output logic      [spqc_pkg::OCC_W-1:0]  rsp_occupancy
);
   import spqc_pkg::*;

   dp_cmd_type cmd;

   // The sequencer owns both handshakes and issues one command set per cycle.
   spqc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // The datapath holds the slots, the fill count and the response register.
   spqc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_type           (req_type),
      .req_entry_key      (req_entry_key),
      .req_urgency        (req_urgency),
      .rsp_status         (rsp_status),
      .rsp_served_key     (rsp_served_key),
      .rsp_served_urgency (rsp_served_urgency),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

`default_nettype wire

FILE: rtl/core/spqc_dp.sv
// ============================================================================
// spqc_dp: slot chain datapath
// Holds the ordered slots as a chain of cells, compares every slot against
// the request in parallel, and shifts the chain to insert or remove an entry.
// ============================================================================
`default_nettype none

module spqc_dp (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire spqc_pkg::dp_cmd_type        cmd,
   input  wire logic [spqc_pkg::TYPE_W-1:0] req_type,
   input  wire logic [spqc_pkg::KEY_W-1:0]  req_entry_key,
   input  wire logic [spqc_pkg::URG_W-1:0]  req_urgency,
   output logic      [spqc_pkg::STAT_W-1:0] rsp_status,
   output logic      [spqc_pkg::KEY_W-1:0]  rsp_served_key,
   output logic      [spqc_pkg::URG_W-1:0]  rsp_served_urgency,
   output logic      [spqc_pkg::OCC_W-1:0]  rsp_occupancy
);
   import spqc_pkg::*;

   logic [TYPE_W-1:0]   op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [URG_W-1:0]    urg_ff;

   logic [KEY_BITS-1:0] slot_key_ff [CAPACITY];
   logic [URG_W-1:0]    slot_urg_ff [CAPACITY];
   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;

   logic [CAPACITY-1:0] vld;
   logic [CAPACITY-1:0] match_in;
   logic [CAPACITY-1:0] gt_in;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] gt_ff;
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] rm;
   logic [CAPACITY-1:0] ins;

   logic is_enq;
   logic is_deq;
   logic is_cancel;
   logic full;
   logic empty;
   logic found;
   logic do_ins;
   logic do_rm;

   logic [URG_W-1:0]    rm_urg;
   logic [STAT_W-1:0]   status_in;
   logic [KEY_W-1:0]    skey_in;
   logic [URG_W-1:0]    surg_in;

   logic [STAT_W-1:0]   status_ff;
   logic [KEY_W-1:0]    skey_ff;
   logic [URG_W-1:0]    surg_ff;
   logic [OCC_W-1:0]    occ_ff;

   // Request capture; urgency zero is treated as the most urgent level.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_type;
         key_ff <= KEY_BITS'(req_entry_key);
         urg_ff <= (req_urgency == '0) ? URG_W'(1) : req_urgency;
      end
   end

   always_comb begin
      is_enq    = (op_ff == REQ_ENQ);
      is_deq    = (op_ff == REQ_DEQ);
      is_cancel = (op_ff == REQ_CANCEL);
      full      = (fill_ff == FILL_W'(CAPACITY));
      empty     = (fill_ff == '0);
      found     = |match_ff;
      do_ins    = is_enq && !full;
      do_rm     = (is_deq && !empty) || (is_cancel && found);
      if (is_deq) begin
         rm = CAPACITY'(vld[0]);
      end else if (is_cancel) begin
         rm = hit;
      end else begin
         rm = '0;
      end
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         localparam logic [CAPACITY-1:0] BELOW = ~({CAPACITY{1'b1}} << i);
         localparam logic [CAPACITY-1:0] UPTO  = ~({CAPACITY{1'b1}} << (i + 1));

         logic                take_prev;
         logic                take_new;
         logic                take_next;
         logic [KEY_BITS-1:0] prev_key;
         logic [URG_W-1:0]    prev_urg;
         logic [KEY_BITS-1:0] next_key;
         logic [URG_W-1:0]    next_urg;

         assign vld[i]      = (fill_ff > FILL_W'(i));
         assign match_in[i] = vld[i] && (slot_key_ff[i] == key_ff);
         assign gt_in[i]    = vld[i] && (slot_urg_ff[i] > urg_ff);
         assign hit[i]      = match_ff[i] && !(|(match_ff & BELOW));
         // The insertion point and everything behind it.
         assign ins[i]      = gt_ff[i] || !vld[i];

         // The head cell has no neighbor in front and the tail cell none
         // behind; those sides never shift in.
         if (i == 0) begin : g_head
            assign take_prev = 1'b0;
            assign take_new  = do_ins && ins[i];
            assign prev_key  = '0;
            assign prev_urg  = '0;
         end else begin : g_body
            assign take_prev = do_ins && ins[i-1];
            assign take_new  = do_ins && ins[i] && !ins[i-1];
            assign prev_key  = slot_key_ff[i-1];
            assign prev_urg  = slot_urg_ff[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign take_next = 1'b0;
            assign next_key  = '0;
            assign next_urg  = '0;
         end else begin : g_mid
            assign take_next = do_rm && (|(rm & UPTO));
            assign next_key  = slot_key_ff[i+1];
            assign next_urg  = slot_urg_ff[i+1];
         end

         always_ff @(posedge clock) begin
            if (cmd.commit) begin
               if (take_new) begin
                  slot_key_ff[i] <= key_ff;
                  slot_urg_ff[i] <= urg_ff;
               end else if (take_prev) begin
                  slot_key_ff[i] <= prev_key;
                  slot_urg_ff[i] <= prev_urg;
               end else if (take_next) begin
                  slot_key_ff[i] <= next_key;
                  slot_urg_ff[i] <= next_urg;
               end
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         match_ff <= match_in;
         gt_ff    <= gt_in;
      end
   end

   // The removed slot is one-hot, so an OR over the masked urgencies selects it.
   always_comb begin
      rm_urg = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rm_urg = rm_urg | (slot_urg_ff[k] & {URG_W{rm[k]}});
      end
   end

   always_comb begin
      fill_in   = fill_ff;
      status_in = ST_OK;
      skey_in   = '0;
      surg_in   = '0;
      if (do_ins) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_rm) begin
         fill_in = fill_ff - FILL_W'(1);
      end
      if (is_enq) begin
         status_in = full ? ST_FULL : ST_OK;
      end else if (is_deq) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else begin
            skey_in = KEY_W'(slot_key_ff[0]);
            surg_in = rm_urg;
         end
      end else if (is_cancel) begin
         if (found) begin
            skey_in = KEY_W'(key_ff);
            surg_in = rm_urg;
         end else begin
            status_in = ST_NOTFOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.commit) begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         skey_ff   <= skey_in;
         surg_ff   <= surg_in;
         occ_ff    <= OCC_W'(fill_in);
      end
   end

   assign rsp_status         = status_ff;
   assign rsp_served_key     = skey_ff;
   assign rsp_served_urgency = surg_ff;
   assign rsp_occupancy      = occ_ff;

endmodule

`default_nettype wire

FILE: rtl/core/spqc_ctrl.sv
// ============================================================================
// spqc_ctrl: request sequencer
// Steps each request through lookup and execute, and owns the handshakes.
// ============================================================================
`default_nettype none

module spqc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output spqc_pkg::dp_cmd_type      cmd
);
   import spqc_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = FSM_LOOKUP;
            end
         end
         FSM_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               req_ready  = 1'b1;
               state_in   = req_valid ? FSM_LOOKUP : FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
      cmd.load_req = req_valid && req_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire
